// File: rtl/uch_pkg.sv
// Shared types, codes and helpers for the unacked command history block.
// No dependencies; imported by every module of the block except uch_ram.
package uch_pkg;

  localparam int HIST_DEPTH_DEF = 16;
  localparam int SEQ_W          = 16;
  localparam int STAMP_W        = 48;
  localparam int MOVE_W         = 8;
  localparam int YAW_W          = 16;
  localparam int FLAG_W         = 5;
  localparam int MODE_W         = 2;
  localparam int KIND_W         = 2;

  localparam logic [SEQ_W-1:0] NEWER_LIMIT = 16'h8000;

  typedef enum logic [MODE_W-1:0] {
    MODE_CAPTURE = 2'd0,
    MODE_ACK     = 2'd1,
    MODE_CLEAR   = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CAPTURE = 2'd0,
    KIND_PENDING = 2'd1,
    KIND_EMPTY   = 2'd2,
    KIND_CLEARED = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAP_RD,
    ST_CAP_WR,
    ST_CLR,
    ST_ACK_CNT,
    ST_ACK_EMPTY,
    ST_ACK_SEL,
    ST_ACK_EMIT,
    ST_ACK_NEXT
  } state_t;

  // One stored command
  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic [STAMP_W-1:0] stamp;
    logic [MOVE_W-1:0]  move_x;
    logic [MOVE_W-1:0]  move_y;
    logic [MOVE_W-1:0]  move_z;
    logic [YAW_W-1:0]   yaw;
    logic [FLAG_W-1:0]  flags;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // latch request fields
    logic cap_rd;      // read slot at write pointer
    logic cap_wr;      // write slot, emit capture result
    logic scan_start;  // start a pass over all slots
    logic count_pass;  // with scan_start: counting pass, else selection pass
    logic emit_best;   // emit selected pending entry
    logic emit_empty;  // emit "nothing pending"
    logic emit_clear;  // invalidate all slots, emit "cleared"
  } uch_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic pend_any;
    logic out_free;
  } uch_sts_t;

  function automatic logic is_newer(input logic [SEQ_W-1:0] s,
                                    input logic [SEQ_W-1:0] r);
    logic [SEQ_W-1:0] d;
    d = s - r;
    return (s != r) && (d < NEWER_LIMIT);
  endfunction

endpackage

// File: rtl/uch_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module uch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/uch_ctrl.sv
// Sequencing controller for the unacked command history.
// Depends on uch_pkg; drives the datapath through uch_cmd_t.
module uch_ctrl
  import uch_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [MODE_W-1:0] in_mode,
  output logic              in_ready,
  input  uch_sts_t          sts,
  output uch_cmd_t          cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (mode_t'(in_mode))
            MODE_CAPTURE: state_nxt = ST_CAP_RD;
            MODE_ACK:     state_nxt = ST_ACK_CNT;
            MODE_CLEAR:   state_nxt = ST_CLR;
            default:      state_nxt = ST_IDLE;
          endcase
          if (mode_t'(in_mode) == MODE_ACK) begin
            cmd.scan_start = 1'b1;
            cmd.count_pass = 1'b1;
          end
        end
      end
      ST_CAP_RD: begin
        cmd.cap_rd = 1'b1;
        state_nxt  = ST_CAP_WR;
      end
      ST_CAP_WR: begin
        if (sts.out_free) begin
          cmd.cap_wr = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_CLR: begin
        if (sts.out_free) begin
          cmd.emit_clear = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_ACK_CNT: begin
        if (sts.scan_done) begin
          if (sts.pend_any) begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_ACK_SEL;
          end else begin
            state_nxt = ST_ACK_EMPTY;
          end
        end
      end
      ST_ACK_EMPTY: begin
        if (sts.out_free) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_ACK_SEL: begin
        if (sts.scan_done) begin
          state_nxt = ST_ACK_EMIT;
        end
      end
      ST_ACK_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_best = 1'b1;
          state_nxt     = ST_ACK_NEXT;
        end
      end
      ST_ACK_NEXT: begin
        if (sts.pend_any) begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_ACK_SEL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/uch_dp.sv
// Datapath: request registers, history store, slot scan and result register.
// Depends on uch_pkg and uch_ram; steered by uch_ctrl.
module uch_dp
  import uch_pkg::*;
#(
  parameter int HISTORY_DEPTH = HIST_DEPTH_DEF,
  localparam int IDX_W = $clog2(HISTORY_DEPTH),
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  uch_cmd_t            cmd,
  output uch_sts_t            sts,
  input  logic [MODE_W-1:0]   in_mode,
  input  entry_t              in_entry,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KIND_W-1:0]   out_kind,
  output entry_t              out_entry,
  output logic [CNT_W-1:0]    out_pending_count,
  output logic                out_overflow,
  output logic                out_last_of_run
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

  entry_t                     req_r;
  logic [SEQ_W-1:0]           acked_r;
  logic [IDX_W-1:0]           wp_r;
  logic [HISTORY_DEPTH-1:0]   valid_r, valid_nxt;
  logic [HISTORY_DEPTH-1:0]   pend_r, pend_nxt;
  logic [CNT_W-1:0]           cnt_r;

  logic                       scan_act_r, scan_vld_r, count_pass_r;
  logic [IDX_W-1:0]           scan_idx_r, rd_idx_r;

  entry_t                     best_r;
  logic [SEQ_W-1:0]           best_dist_r;
  logic [IDX_W-1:0]           best_idx_r;
  logic                       best_found_r;

  logic                       out_valid_r, out_ovf_r, out_last_r;
  kind_t                      out_kind_r;
  entry_t                     out_entry_r;
  logic [CNT_W-1:0]           out_cnt_r;

  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  logic [$bits(entry_t)-1:0]  rd_data;
  entry_t                     rd_entry;
  logic [SEQ_W-1:0]           rd_dist;
  logic                       rd_newer;
  logic                       take;
  logic [HISTORY_DEPTH-1:0]   best_mask;
  logic                       out_free;

  assign rd_en    = cmd.cap_rd | scan_act_r;
  assign rd_addr  = cmd.cap_rd ? wp_r : scan_idx_r;
  assign rd_entry = entry_t'(rd_data);
  assign rd_dist  = rd_entry.seq - acked_r;
  assign rd_newer = valid_r[rd_idx_r] && is_newer(rd_entry.seq, acked_r);
  assign take     = scan_vld_r && !count_pass_r && pend_r[rd_idx_r] &&
                    (!best_found_r || (rd_dist < best_dist_r));
  assign out_free = !out_valid_r || out_ready;

  uch_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (HISTORY_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.cap_wr),
    .wr_addr (wp_r),
    .wr_data (req_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    best_mask             = '0;
    best_mask[best_idx_r] = 1'b1;
    valid_nxt             = valid_r;
    pend_nxt              = pend_r;
    if (scan_vld_r && count_pass_r) begin
      // counting pass drops stale entries and marks the pending ones
      valid_nxt[rd_idx_r] = rd_newer;
      pend_nxt[rd_idx_r]  = rd_newer;
    end
    if (cmd.cap_wr) begin
      valid_nxt[wp_r] = 1'b1;
    end
    if (cmd.emit_clear) begin
      valid_nxt = '0;
    end
    if (cmd.emit_best) begin
      pend_nxt = pend_r & ~best_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acked_r      <= '0;
      wp_r         <= '0;
      valid_r      <= '0;
      pend_r       <= '0;
      cnt_r        <= '0;
      scan_act_r   <= 1'b0;
      scan_vld_r   <= 1'b0;
      count_pass_r <= 1'b0;
      scan_idx_r   <= '0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      pend_r     <= pend_nxt;
      scan_vld_r <= scan_act_r;

      if (cmd.load && (mode_t'(in_mode) == MODE_ACK)) begin
        acked_r <= in_entry.seq;
      end

      if (cmd.cap_wr) begin
        wp_r <= (wp_r == LAST_IDX) ? '0 : wp_r + IDX_W'(1);
      end else if (cmd.emit_clear) begin
        wp_r <= '0;
      end

      if (cmd.scan_start) begin
        scan_act_r   <= 1'b1;
        scan_idx_r   <= '0;
        count_pass_r <= cmd.count_pass;
        best_found_r <= 1'b0;
        if (cmd.count_pass) begin
          cnt_r <= '0;
        end
      end else if (scan_act_r) begin
        if (scan_idx_r == LAST_IDX) begin
          scan_act_r <= 1'b0;
        end else begin
          scan_idx_r <= scan_idx_r + IDX_W'(1);
        end
      end

      if (scan_vld_r && count_pass_r && rd_newer) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (take) begin
        best_found_r <= 1'b1;
      end

      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.cap_wr || cmd.emit_clear || cmd.emit_empty || cmd.emit_best) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    rd_idx_r <= scan_idx_r;
    if (cmd.load) begin
      req_r <= in_entry;
    end
    if (take) begin
      best_r      <= rd_entry;
      best_dist_r <= rd_dist;
      best_idx_r  <= rd_idx_r;
    end
    if (cmd.cap_wr) begin
      out_kind_r  <= KIND_CAPTURE;
      out_entry_r <= req_r;
      out_cnt_r   <= '0;
      out_ovf_r   <= valid_r[wp_r] && is_newer(rd_entry.seq, acked_r);
      out_last_r  <= 1'b1;
    end else if (cmd.emit_best) begin
      out_kind_r  <= KIND_PENDING;
      out_entry_r <= best_r;
      out_cnt_r   <= cnt_r;
      out_ovf_r   <= 1'b0;
      out_last_r  <= (pend_r & ~best_mask) == '0;
    end else if (cmd.emit_empty || cmd.emit_clear) begin
      out_kind_r  <= cmd.emit_clear ? KIND_CLEARED : KIND_EMPTY;
      out_entry_r <= '0;
      out_cnt_r   <= '0;
      out_ovf_r   <= 1'b0;
      out_last_r  <= 1'b1;
    end
  end

  assign sts.scan_done = !scan_act_r && !scan_vld_r;
  assign sts.pend_any  = |pend_r;
  assign sts.out_free  = out_free;

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_entry         = out_entry_r;
  assign out_pending_count = out_cnt_r;
  assign out_overflow      = out_ovf_r;
  assign out_last_of_run   = out_last_r;

endmodule

// File: rtl/unacked_command_history.sv
// Unacked command history: capture, clear and ack requests; an ack runs a counting pass
// over the slots, then one selection pass per pending entry, with one store read
// per cycle during each pass over the slots. One request at a time.
// Result waits in an output register; the next request is taken while it waits.
// Reset (rst_n low, synchronous): all slots invalid, write pointer and acked number zero.
module unacked_command_history
  import uch_pkg::*;
#(
  parameter int HISTORY_DEPTH = HIST_DEPTH_DEF,
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // request channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [MODE_W-1:0]         in_mode,
  input  logic [SEQ_W-1:0]          in_seq,
  input  logic [STAMP_W-1:0]        in_stamp,
  input  logic signed [MOVE_W-1:0]  in_move_x,
  input  logic signed [MOVE_W-1:0]  in_move_y,
  input  logic signed [MOVE_W-1:0]  in_move_z,
  input  logic signed [YAW_W-1:0]   in_yaw_centi,
  input  logic [FLAG_W-1:0]         in_flag_bits,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [KIND_W-1:0]         out_kind,
  output logic [SEQ_W-1:0]          out_entry_seq,
  output logic [STAMP_W-1:0]        out_entry_stamp,
  output logic signed [MOVE_W-1:0]  out_entry_move_x,
  output logic signed [MOVE_W-1:0]  out_entry_move_y,
  output logic signed [MOVE_W-1:0]  out_entry_move_z,
  output logic signed [YAW_W-1:0]   out_entry_yaw,
  output logic [FLAG_W-1:0]         out_entry_flags,
  output logic [CNT_W-1:0]          out_pending_count,
  output logic                      out_overflow,
  output logic                      out_last_of_run
);

  uch_cmd_t cmd;
  uch_sts_t sts;
  entry_t   in_entry;
  entry_t   out_entry;

  // Request payload packed as a stored entry; on ack only seq matters.
  assign in_entry.seq    = in_seq;
  assign in_entry.stamp  = in_stamp;
  assign in_entry.move_x = in_move_x;
  assign in_entry.move_y = in_move_y;
  assign in_entry.move_z = in_move_z;
  assign in_entry.yaw    = in_yaw_centi;
  assign in_entry.flags  = in_flag_bits;

  // Controller: capture reads the target slot first (overflow check) then writes.
  // Ack runs a counting pass (marks pending slots, drops stale ones), then one
  // selection pass per result picking the smallest modular distance; ties go to
  // the lowest slot because the pass runs in ascending slot order with a strict compare.
  uch_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  uch_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_mode           (in_mode),
    .in_entry          (in_entry),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_entry         (out_entry),
    .out_pending_count (out_pending_count),
    .out_overflow      (out_overflow),
    .out_last_of_run   (out_last_of_run)
  );

  assign out_entry_seq    = out_entry.seq;
  assign out_entry_stamp  = out_entry.stamp;
  assign out_entry_move_x = $signed(out_entry.move_x);
  assign out_entry_move_y = $signed(out_entry.move_y);
  assign out_entry_move_z = $signed(out_entry.move_z);
  assign out_entry_yaw    = $signed(out_entry.yaw);
  assign out_entry_flags  = out_entry.flags;

endmodule

// File: verif/unacked_command_history_tb.sv
// Self-checking testbench for unacked_command_history: directed, back-pressure and random tests.
// Depends on uch_pkg (rtl/uch_pkg.sv) and the unacked_command_history top level.
module unacked_command_history_tb
  import uch_pkg::*;
();

  localparam int DEPTH          = HIST_DEPTH_DEF;
  localparam int COUNT_W        = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS   = 115;
  localparam int CALM_ITEMS     = 30;    // tail of the random test with no idling
  localparam int LONG_HOLD      = 300;   // receiver hold-off for the fill test
  localparam int SETTLE_CYCLES  = 2 * DEPTH + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_MAX     = 10;

  // One request as presented on the input channel
  typedef struct packed {
    mode_t               mode;
    logic [SEQ_W-1:0]    seq;
    logic [STAMP_W-1:0]  stamp;
    logic [MOVE_W-1:0]   mx;
    logic [MOVE_W-1:0]   my;
    logic [MOVE_W-1:0]   mz;
    logic [YAW_W-1:0]    yaw;
    logic [FLAG_W-1:0]   flags;
  } request_t;

  // One result as seen on the output channel
  typedef struct packed {
    kind_t               kind;
    entry_t              entry;
    logic [COUNT_W-1:0]  count;
    logic                ovf;
    logic                last;
  } result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [MODE_W-1:0]         in_mode;
  logic [SEQ_W-1:0]          in_seq;
  logic [STAMP_W-1:0]        in_stamp;
  logic signed [MOVE_W-1:0]  in_move_x;
  logic signed [MOVE_W-1:0]  in_move_y;
  logic signed [MOVE_W-1:0]  in_move_z;
  logic signed [YAW_W-1:0]   in_yaw_centi;
  logic [FLAG_W-1:0]         in_flag_bits;
  logic                      out_valid;
  logic                      out_ready;
  logic [KIND_W-1:0]         out_kind;
  logic [SEQ_W-1:0]          out_entry_seq;
  logic [STAMP_W-1:0]        out_entry_stamp;
  logic signed [MOVE_W-1:0]  out_entry_move_x;
  logic signed [MOVE_W-1:0]  out_entry_move_y;
  logic signed [MOVE_W-1:0]  out_entry_move_z;
  logic signed [YAW_W-1:0]   out_entry_yaw;
  logic [FLAG_W-1:0]         out_entry_flags;
  logic [COUNT_W-1:0]        out_pending_count;
  logic                      out_overflow;
  logic                      out_last_of_run;

  unacked_command_history dut (.*);

  // Shadow of the history: slot valid bits, slot contents, write pointer, acked number
  logic             hist_valid [DEPTH];
  entry_t           hist_store [DEPTH];
  int               hist_wptr;
  logic [SEQ_W-1:0] hist_acked;

  result_t due_results[$];   // results still owed by the block, oldest first
  int      mismatches;
  int      idle_cycles;
  int      hold_req;         // long receiver hold-off asked by a test, in cycles
  int      stall_left;
  bit      calm;             // set for the quiet tail: no idling on either side

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------------

  // Modular distance of a stored number from the acked one
  function automatic logic [SEQ_W-1:0] seq_gap(input logic [SEQ_W-1:0] s,
                                               input logic [SEQ_W-1:0] r);
    return s - r;
  endfunction

  // "Newer": different, and less than half the number space ahead
  function automatic bit ahead_of(input logic [SEQ_W-1:0] s, input logic [SEQ_W-1:0] r);
    logic [SEQ_W-1:0] d;
    d = seq_gap(s, r);
    return (s != r) && !d[SEQ_W-1];
  endfunction

  // Apply one accepted request to the shadow history and queue the results it owes
  task automatic apply_to_history(input request_t c);
    int               order [DEPTH];
    int               n;
    int               i;
    int               j;
    int               v;
    logic [SEQ_W-1:0] dv;
    result_t          r;
    r = '0;
    case (c.mode)
      MODE_CAPTURE: begin
        r.ovf = hist_valid[hist_wptr] && ahead_of(hist_store[hist_wptr].seq, hist_acked);
        hist_store[hist_wptr] = '{seq: c.seq, stamp: c.stamp, move_x: c.mx, move_y: c.my,
                                  move_z: c.mz, yaw: c.yaw, flags: c.flags};
        hist_valid[hist_wptr] = 1'b1;
        r.kind  = KIND_CAPTURE;
        r.entry = hist_store[hist_wptr];
        r.last  = 1'b1;
        hist_wptr = (hist_wptr + 1) % DEPTH;
        due_results.push_back(r);
      end
      MODE_ACK: begin
        hist_acked = c.seq;
        n = 0;
        for (i = 0; i < DEPTH; i++) begin
          if (hist_valid[i] && ahead_of(hist_store[i].seq, hist_acked)) begin
            order[n] = i;
            n++;
          end
        end
        // stable sort by distance: equal numbers keep slot order
        for (i = 1; i < n; i++) begin
          v  = order[i];
          dv = seq_gap(hist_store[v].seq, hist_acked);
          j  = i - 1;
          while (j >= 0 && seq_gap(hist_store[order[j]].seq, hist_acked) > dv) begin
            order[j + 1] = order[j];
            j--;
          end
          order[j + 1] = v;
        end
        if (n == 0) begin
          r.kind = KIND_EMPTY;
          r.last = 1'b1;
          due_results.push_back(r);
        end
        for (i = 0; i < n; i++) begin
          r.kind  = KIND_PENDING;
          r.entry = hist_store[order[i]];
          r.count = COUNT_W'(n);
          r.last  = (i == n - 1);
          due_results.push_back(r);
        end
        // everything no longer ahead of the acked number is retired
        for (i = 0; i < DEPTH; i++) begin
          if (hist_valid[i] && !ahead_of(hist_store[i].seq, hist_acked))
            hist_valid[i] = 1'b0;
        end
      end
      MODE_CLEAR: begin
        for (i = 0; i < DEPTH; i++) begin
          hist_valid[i] = 1'b0;
          hist_store[i] = '0;
        end
        hist_wptr = 0;
        r.kind = KIND_CLEARED;
        r.last = 1'b1;
        due_results.push_back(r);
      end
      default: ;  // unused mode: no state change, no result
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  function automatic request_t make_request(input mode_t m, input logic [SEQ_W-1:0] s);
    request_t c;
    c.mode  = m;
    c.seq   = s;
    c.stamp = {16'($urandom), 32'($urandom)};
    c.mx    = MOVE_W'($urandom_range(0, 254) - 127);
    c.my    = MOVE_W'($urandom_range(0, 254) - 127);
    c.mz    = MOVE_W'($urandom_range(0, 254) - 127);
    c.yaw   = YAW_W'($urandom);
    c.flags = FLAG_W'($urandom);
    return c;
  endfunction

  // Offer one request and hold it until accepted; valid is left high so that a
  // following request goes out back to back.
  task automatic send_request(input request_t c);
    in_valid     <= 1'b1;
    in_mode      <= c.mode;
    in_seq       <= c.seq;
    in_stamp     <= c.stamp;
    in_move_x    <= c.mx;
    in_move_y    <= c.my;
    in_move_z    <= c.mz;
    in_yaw_centi <= c.yaw;
    in_flag_bits <= c.flags;
    do @(posedge clk); while (in_ready !== 1'b1);
    apply_to_history(c);
  endtask

  // Occasional burst of idle cycles on the request side
  task automatic request_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Stop offering until every owed result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every mode, sort order, equal numbers, the half-range edge,
  // wrap-around, the unused mode and clear.
  task automatic test_directed();
    request_t c;
    c = make_request(MODE_ACK, 16'h0000);             // nothing pending yet
    send_request(c); request_gap();
    c = make_request(MODE_CAPTURE, 16'h0001);         // lowest payload values
    c.stamp = '0; c.mx = -8'sd127; c.my = -8'sd127; c.mz = -8'sd127;
    c.yaw = 16'h8000; c.flags = '0;
    send_request(c); request_gap();
    c = make_request(MODE_CAPTURE, 16'h0003);         // highest payload values
    c.stamp = '1; c.mx = 8'sd127; c.my = 8'sd127; c.mz = 8'sd127;
    c.yaw = 16'h7FFF; c.flags = '1;
    send_request(c); request_gap();
    c = make_request(MODE_CAPTURE, 16'h0002);         // out of slot order
    send_request(c); request_gap();
    send_request(make_request(MODE_ACK, 16'h0001)); request_gap();
    send_request(make_request(MODE_CAPTURE, 16'h0005)); request_gap();
    send_request(make_request(MODE_CAPTURE, 16'h0005)); request_gap();  // same number twice
    send_request(make_request(MODE_CAPTURE, 16'h8004)); request_gap();  // exactly half away
    send_request(make_request(MODE_ACK, 16'h0004)); request_gap();
    send_request(make_request(MODE_CAPTURE, 16'hFFFE)); request_gap();
    send_request(make_request(MODE_CAPTURE, 16'h0001)); request_gap();
    send_request(make_request(MODE_ACK, 16'hFFFD)); request_gap();      // across the wrap
    send_request(make_request(MODE_NONE, 16'hFFFF)); request_gap();     // ignored
    send_request(make_request(MODE_CLEAR, 16'h1234)); request_gap();
    send_request(make_request(MODE_ACK, 16'hFFFD)); request_gap();      // empty after clear
    send_request(make_request(MODE_CAPTURE, 16'hAAAA)); request_gap();
    send_request(make_request(MODE_CLEAR, 16'h5555));
  endtask

  // Receiver holds off while captures keep coming: the block backs up, then the
  // ring wraps onto an unacked slot. A full ack then emits the whole ring.
  task automatic test_fill_and_stall();
    int i;
    hold_req = LONG_HOLD;
    for (i = 0; i <= DEPTH; i++)
      send_request(make_request(MODE_CAPTURE, 16'hFFFE + SEQ_W'(i)));
    drain_results();
    send_request(make_request(MODE_ACK, 16'hFFFD));
    drain_results();
  endtask

  // Mostly a plausible session (rising capture numbers, acks a little behind),
  // with clears, stray numbers, jumps and the unused mode mixed in.
  task automatic test_random();
    int               done;
    int               pick;
    logic [SEQ_W-1:0] seq_cursor;
    seq_cursor = SEQ_W'($urandom);
    done = 0;
    while (done < RANDOM_ITEMS) begin
      calm = (done >= RANDOM_ITEMS - CALM_ITEMS);
      pick = $urandom_range(0, 99);
      if (pick < 3)
        seq_cursor = SEQ_W'($urandom);
      if (pick < 55) begin
        send_request(make_request(MODE_CAPTURE, seq_cursor));
        seq_cursor++;
        done++;
      end else if (pick < 70) begin
        send_request(make_request(MODE_ACK, seq_cursor - 1'b1));
        done++;
      end else if (pick < 85) begin
        send_request(make_request(MODE_ACK, seq_cursor - SEQ_W'($urandom_range(2, 20))));
        done++;
      end else if (pick < 89) begin
        send_request(make_request(MODE_CLEAR, SEQ_W'($urandom)));
        done++;
      end else if (pick < 93) begin
        send_request(make_request(MODE_NONE, SEQ_W'($urandom)));
      end else begin
        send_request(make_request(pick[0] ? MODE_ACK : MODE_CAPTURE, SEQ_W'($urandom)));
        done++;
      end
      request_gap();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pattern, checking, watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_req > 0) begin
      stall_left = hold_req;
      hold_req   = 0;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(1, 18) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      got.kind         = kind_t'(out_kind);
      got.entry.seq    = out_entry_seq;
      got.entry.stamp  = out_entry_stamp;
      got.entry.move_x = out_entry_move_x;
      got.entry.move_y = out_entry_move_y;
      got.entry.move_z = out_entry_move_z;
      got.entry.yaw    = out_entry_yaw;
      got.entry.flags  = out_entry_flags;
      got.count        = out_pending_count;
      got.ovf          = out_overflow;
      got.last         = out_last_of_run;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: kind %0d seq %h", got.kind, got.entry.seq);
      end else begin
        want = due_results.pop_front();
        if (got.kind !== want.kind || got.entry.seq !== want.entry.seq ||
            got.entry.stamp !== want.entry.stamp || got.entry.move_x !== want.entry.move_x ||
            got.entry.move_y !== want.entry.move_y || got.entry.move_z !== want.entry.move_z ||
            got.entry.yaw !== want.entry.yaw || got.entry.flags !== want.entry.flags ||
            got.count !== want.count || got.ovf !== want.ovf || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("mismatch exp/act: kind %0d/%0d seq %h/%h stamp %h/%h",
                     want.kind, got.kind, want.entry.seq, got.entry.seq,
                     want.entry.stamp, got.entry.stamp);
            $display("  mv %h%h%h/%h%h%h yaw %h/%h flags %h/%h",
                     want.entry.move_x, want.entry.move_y, want.entry.move_z,
                     got.entry.move_x, got.entry.move_y, got.entry.move_z,
                     want.entry.yaw, got.entry.yaw, want.entry.flags, got.entry.flags);
            $display("  cnt %0d/%0d ovf %b/%b last %b/%b",
                     want.count, got.count, want.ovf, got.ovf, want.last, got.last);
          end
        end
      end
    end
  end

  // Watchdog: too long without any request or result moving
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready === 1'b1))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("unacked_command_history_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------------

  initial begin
    int i;
    for (i = 0; i < DEPTH; i++) begin
      hist_valid[i] = 1'b0;
      hist_store[i] = '0;
    end
    hist_wptr    = 0;
    hist_acked   = '0;
    mismatches   = 0;
    idle_cycles  = 0;
    hold_req     = 0;
    stall_left   = 0;
    calm         = 1'b0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_mode      <= MODE_NONE;
    in_seq       <= '0;
    in_stamp     <= '0;
    in_move_x    <= '0;
    in_move_y    <= '0;
    in_move_z    <= '0;
    in_yaw_centi <= '0;
    in_flag_bits <= '0;
    out_ready    <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fill_and_stall();
    test_random();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0)
      $display("unacked_command_history_tb OK");
    else
      $display("unacked_command_history_tb NOT OK");
    $finish;
  end

endmodule

// File: files.f
rtl/uch_pkg.sv
rtl/uch_ram.sv
rtl/uch_ctrl.sv
rtl/uch_dp.sv
rtl/unacked_command_history.sv
verif/unacked_command_history_tb.sv
